// File: rtl/fcl_pkg.sv
`default_nettype none

package fcl_pkg;

    localparam int COUNT_BITS_DEF = 32;

    localparam int FREQ_W  = 32;
    localparam int NUM_W   = 20;
    localparam int DEN_W   = 20;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int TIME_W  = 64;
    localparam int PROD_W  = FREQ_W + NUM_W;
    localparam int SUM_W   = TIME_W + 1;
    localparam int OUT_CNT_W = 32;

    localparam logic [IDX_W-1:0] REG_TICK_FREQ = 2'd0;
    localparam logic [IDX_W-1:0] REG_FPS_NUM   = 2'd1;
    localparam logic [IDX_W-1:0] REG_FPS_DEN   = 2'd2;

    typedef enum logic [1:0] {
        DEC_ACCEPT   = 2'd0,
        DEC_LIMITED  = 2'd1,
        DEC_BAD_TIME = 2'd2,
        DEC_BAD_CFG  = 2'd3
    } decision_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IVL,
        S_TIME,
        S_ELAP,
        S_MLO,
        S_MHI,
        S_SUM,
        S_DIFF,
        S_LATE,
        S_STEP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [FREQ_W-1:0] mul_a;
        logic [NUM_W-1:0]  mul_b;
        logic [SUM_W-1:0]  add_a;
        logic [SUM_W-1:0]  add_b;
        logic              add_sub;
    } alu_req_t;

    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic [SUM_W-1:0]  sum;
    } alu_rsp_t;

endpackage

`default_nettype wire

// File: rtl/frame_cadence_limiter_top.sv
// Frame cadence limiter: takes one 64-bit frame timestamp per word and answers with one
// result word holding the decision (accepted, rate limited, invalid timestamp, invalid
// configuration), a rebase flag and six wrapping statistics counters. Each frame is worked
// through by a small sequencer that drives one shared 32x20 multiplier and one shared
// 65-bit adder; frames rejected for configuration or time leave after the time check,
// while cadence checks go on through the elapsed, multiply and sum states and may leave
// at sum or difference before the late and step states. The input is not ready while a
// frame is in work; a finished result waits in an output register so the next frame can
// be taken meanwhile. Configuration must be written only while no frame is in work or
// waiting; a write of a known register clears the schedule and all counters.
`default_nettype none

module frame_cadence_limiter_top
    import fcl_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [TIME_W-1:0]    frame_time,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                decision,
    output logic                      rebased,
    output logic [OUT_CNT_W-1:0]      seen_count,
    output logic [OUT_CNT_W-1:0]      accept_count,
    output logic [OUT_CNT_W-1:0]      limited_count,
    output logic [OUT_CNT_W-1:0]      bad_time_count,
    output logic [OUT_CNT_W-1:0]      bad_config_count,
    output logic [OUT_CNT_W-1:0]      rebase_count
);

    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    state_t state_reg, state_next;

    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;

    logic              started_reg, started_next;
    logic [62:0]       base_reg, base_next;
    logic [62:0]       last_reg, last_next;
    logic [63:0]       due_reg, due_next;

    logic [COUNT_BITS-1:0] seen_reg, seen_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0] lim_reg, lim_next;
    logic [COUNT_BITS-1:0] badt_reg, badt_next;
    logic [COUNT_BITS-1:0] badc_reg, badc_next;
    logic [COUNT_BITS-1:0] reb_cnt_reg, reb_cnt_next;

    logic              out_valid_reg, out_valid_next;
    decision_t         out_dec_reg, out_dec_next;
    logic              out_reb_reg, out_reb_next;

    logic [TIME_W-1:0] t_reg, t_next;
    logic [PROD_W-1:0] interval_reg, interval_next;
    logic [62:0]       elapsed_reg, elapsed_next;
    logic [PROD_W-1:0] plo_reg, plo_next;
    logic [50:0]       phi_reg, phi_next;
    logic [63:0]       scaled_reg, scaled_next;
    logic              late_pos_reg, late_pos_next;
    logic [63:0]       late_reg, late_next;
    decision_t         dec_reg, dec_next;
    logic              reb_reg, reb_next;

    alu_req_t          req;
    alu_rsp_t          rsp;
    logic              restart;
    logic              cfg_bad;

    logic [63:0] seen_w, acc_w, lim_w, badt_w, badc_w, reb_w;

    fcl_alu u_alu (
        .req (req),
        .rsp (rsp)
    );

    assign cfg_bad = (freq_reg == '0) || (num_reg == '0) || (den_reg == '0) ||
                     (interval_reg < PROD_W'(num_reg));

    always_comb
    begin
        state_next     = state_reg;
        freq_next      = freq_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        started_next   = started_reg;
        base_next      = base_reg;
        last_next      = last_reg;
        due_next       = due_reg;
        seen_next      = seen_reg;
        acc_next       = acc_reg;
        lim_next       = lim_reg;
        badt_next      = badt_reg;
        badc_next      = badc_reg;
        reb_cnt_next   = reb_cnt_reg;
        out_valid_next = out_valid_reg;
        out_dec_next   = out_dec_reg;
        out_reb_next   = out_reb_reg;
        t_next         = t_reg;
        interval_next  = interval_reg;
        elapsed_next   = elapsed_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        scaled_next    = scaled_reg;
        late_pos_next  = late_pos_reg;
        late_next      = late_reg;
        dec_next       = dec_reg;
        reb_next       = reb_reg;
        req            = '0;
        restart        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    t_next     = frame_time;
                    state_next = S_IVL;
                end
            end
            S_IVL:
            begin
                req.mul_a     = freq_reg;
                req.mul_b     = den_reg;
                interval_next = rsp.product;
                state_next    = S_TIME;
            end
            S_TIME:
            begin
                // Borrow of t - last_time flags a backward timestamp.
                req.add_a   = {2'b00, t_reg[62:0]};
                req.add_b   = {2'b00, last_reg};
                req.add_sub = 1'b1;
                reb_next    = 1'b0;
                if (cfg_bad)
                begin
                    dec_next   = DEC_BAD_CFG;
                    state_next = S_DONE;
                end
                else if (t_reg[63] || (started_reg && rsp.sum[SUM_W-1]))
                begin
                    dec_next   = DEC_BAD_TIME;
                    state_next = S_DONE;
                end
                else
                begin
                    last_next = t_reg[62:0];
                    if (!started_reg)
                    begin
                        restart    = 1'b1;
                        dec_next   = DEC_ACCEPT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ELAP;
                    end
                end
            end
            S_ELAP:
            begin
                req.add_a    = {2'b00, t_reg[62:0]};
                req.add_b    = {2'b00, base_reg};
                req.add_sub  = 1'b1;
                elapsed_next = rsp.sum[62:0];
                state_next   = S_MLO;
            end
            S_MLO:
            begin
                req.mul_a  = elapsed_reg[31:0];
                req.mul_b  = num_reg;
                plo_next   = rsp.product;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                req.mul_a  = {1'b0, elapsed_reg[62:32]};
                req.mul_b  = num_reg;
                phi_next   = rsp.product[50:0];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // Upper word of elapsed*numerator; anything above bit 63 is overflow.
                req.add_a = SUM_W'(plo_reg[PROD_W-1:32]);
                req.add_b = SUM_W'(phi_reg);
                if (|rsp.sum[SUM_W-1:32])
                begin
                    restart    = 1'b1;
                    dec_next   = DEC_ACCEPT;
                    reb_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    scaled_next = {rsp.sum[31:0], plo_reg[31:0]};
                    state_next  = S_DIFF;
                end
            end
            S_DIFF:
            begin
                req.add_a   = {1'b0, due_reg};
                req.add_b   = {1'b0, scaled_reg};
                req.add_sub = 1'b1;
                if (!rsp.sum[SUM_W-1] &&
                    ((|rsp.sum[63:NUM_W]) || (rsp.sum[NUM_W-1:0] > num_reg)))
                begin
                    dec_next   = DEC_LIMITED;
                    state_next = S_DONE;
                end
                else
                begin
                    late_pos_next = rsp.sum[SUM_W-1];
                    state_next    = S_LATE;
                end
            end
            S_LATE:
            begin
                req.add_a   = {1'b0, scaled_reg};
                req.add_b   = {1'b0, due_reg};
                req.add_sub = 1'b1;
                late_next   = late_pos_reg ? rsp.sum[63:0] : '0;
                state_next  = S_STEP;
            end
            S_STEP:
            begin
                // A carry out of due + interval means the due point would overflow.
                req.add_a = {1'b0, due_reg};
                req.add_b = SUM_W'(interval_reg);
                dec_next  = DEC_ACCEPT;
                if ((late_reg >= 64'(interval_reg)) || rsp.sum[SUM_W-1])
                begin
                    restart  = 1'b1;
                    reb_next = 1'b1;
                end
                else
                begin
                    due_next = rsp.sum[63:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    seen_next = seen_reg + CNT_ONE;
                    unique case (dec_reg)
                        DEC_ACCEPT:   acc_next  = acc_reg + CNT_ONE;
                        DEC_LIMITED:  lim_next  = lim_reg + CNT_ONE;
                        DEC_BAD_TIME: badt_next = badt_reg + CNT_ONE;
                        DEC_BAD_CFG:  badc_next = badc_reg + CNT_ONE;
                        default:      seen_next = seen_reg + CNT_ONE;
                    endcase
                    if (reb_reg)
                    begin
                        reb_cnt_next = reb_cnt_reg + CNT_ONE;
                    end
                    out_dec_next   = dec_reg;
                    out_reb_next   = reb_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (restart)
        begin
            base_next    = t_reg[62:0];
            last_next    = t_reg[62:0];
            due_next     = 64'(interval_next);
            started_next = 1'b1;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TICK_FREQ: freq_next = cfg_data[FREQ_W-1:0];
                REG_FPS_NUM:   num_next  = cfg_data[NUM_W-1:0];
                REG_FPS_DEN:   den_next  = cfg_data[DEN_W-1:0];
                default:       freq_next = freq_reg;
            endcase
            if ((cfg_index == REG_TICK_FREQ) || (cfg_index == REG_FPS_NUM) ||
                (cfg_index == REG_FPS_DEN))
            begin
                started_next = 1'b0;
                base_next    = '0;
                last_next    = '0;
                due_next     = '0;
                seen_next    = '0;
                acc_next     = '0;
                lim_next     = '0;
                badt_next    = '0;
                badc_next    = '0;
                reb_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            freq_reg      <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            started_reg   <= 1'b0;
            base_reg      <= '0;
            last_reg      <= '0;
            due_reg       <= '0;
            seen_reg      <= '0;
            acc_reg       <= '0;
            lim_reg       <= '0;
            badt_reg      <= '0;
            badc_reg      <= '0;
            reb_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            freq_reg      <= freq_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            started_reg   <= started_next;
            base_reg      <= base_next;
            last_reg      <= last_next;
            due_reg       <= due_next;
            seen_reg      <= seen_next;
            acc_reg       <= acc_next;
            lim_reg       <= lim_next;
            badt_reg      <= badt_next;
            badc_reg      <= badc_next;
            reb_cnt_reg   <= reb_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dec_reg  <= out_dec_next;
        out_reb_reg  <= out_reb_next;
        t_reg        <= t_next;
        interval_reg <= interval_next;
        elapsed_reg  <= elapsed_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        scaled_reg   <= scaled_next;
        late_pos_reg <= late_pos_next;
        late_reg     <= late_next;
        dec_reg      <= dec_next;
        reb_reg      <= reb_next;
    end

    // Counters move only on a result load or config clear and feed the outputs directly.
    assign seen_w = 64'(seen_reg);
    assign acc_w  = 64'(acc_reg);
    assign lim_w  = 64'(lim_reg);
    assign badt_w = 64'(badt_reg);
    assign badc_w = 64'(badc_reg);
    assign reb_w  = 64'(reb_cnt_reg);

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign decision         = out_dec_reg;
    assign rebased          = out_reb_reg;
    assign seen_count       = seen_w[OUT_CNT_W-1:0];
    assign accept_count     = acc_w[OUT_CNT_W-1:0];
    assign limited_count    = lim_w[OUT_CNT_W-1:0];
    assign bad_time_count   = badt_w[OUT_CNT_W-1:0];
    assign bad_config_count = badc_w[OUT_CNT_W-1:0];
    assign rebase_count     = reb_w[OUT_CNT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/fcl_alu.sv
`default_nettype none

module fcl_alu
    import fcl_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [SUM_W-1:0] b_op;

    // Subtraction is a + ~b + 1; bit 64 of the result is the borrow.
    assign b_op        = req.add_sub ? ~req.add_b : req.add_b;
    assign rsp.sum     = req.add_a + b_op + SUM_W'(req.add_sub);
    assign rsp.product = PROD_W'(req.mul_a) * PROD_W'(req.mul_b);

endmodule

`default_nettype wire

// File: rtl/fcl_checker.sv
`default_nettype none

module fcl_checker
    import fcl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] decision,
    input wire logic       rebased
);

    // A stalled result word holds its decision.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(decision) && $stable(rebased))
        else $error("result word changed while stalled");

    // Only an accepted frame can restart the schedule.
    a_rebase_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rebased |-> decision == DEC_ACCEPT)
        else $error("rebase flagged on a frame that was not accepted");

    // The sequencer leaves idle on taking a frame, so the input is not ready right after acceptance.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after acceptance");

endmodule

bind frame_cadence_limiter_top fcl_checker u_fcl_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
    import fcl_pkg::*;

    localparam int LATENCY_WAIT = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        decision_t             decision;
        logic                  rebased;
        logic [OUT_CNT_W-1:0]  seen;
        logic [OUT_CNT_W-1:0]  accepted;
        logic [OUT_CNT_W-1:0]  limited;
        logic [OUT_CNT_W-1:0]  bad_time;
        logic [OUT_CNT_W-1:0]  bad_cfg;
        logic [OUT_CNT_W-1:0]  rebases;
    } frame_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [TIME_W-1:0]     frame_time = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            decision;
    logic                  rebased;
    logic [OUT_CNT_W-1:0]  seen_count;
    logic [OUT_CNT_W-1:0]  accept_count;
    logic [OUT_CNT_W-1:0]  limited_count;
    logic [OUT_CNT_W-1:0]  bad_time_count;
    logic [OUT_CNT_W-1:0]  bad_config_count;
    logic [OUT_CNT_W-1:0]  rebase_count;

    frame_cadence_limiter_top DUT (.*);

    // Shadow of the limiter: configuration, schedule and counters.
    logic [FREQ_W-1:0]     cfg_freq = '0;
    logic [NUM_W-1:0]      cfg_num = '0;
    logic [DEN_W-1:0]      cfg_den = '0;
    logic                  sched_started = 1'b0;
    logic [63:0]           sched_base = '0;
    logic [63:0]           sched_last = '0;
    logic [63:0]           due_point = '0;
    logic [OUT_CNT_W-1:0]  cnt_seen = '0;
    logic [OUT_CNT_W-1:0]  cnt_accept = '0;
    logic [OUT_CNT_W-1:0]  cnt_limited = '0;
    logic [OUT_CNT_W-1:0]  cnt_bad_time = '0;
    logic [OUT_CNT_W-1:0]  cnt_bad_cfg = '0;
    logic [OUT_CNT_W-1:0]  cnt_rebase = '0;

    frame_result_t         pending_results[$];
    frame_result_t         last_prediction;
    int                    send_idle_pct = 0;
    int                    stall_pct = 0;
    int                    fault_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rnd_below(input logic [63:0] n);
        return (n == 0) ? 64'd0 : rnd64() % n;
    endfunction

    function automatic logic [63:0] cadence_interval();
        return 64'(cfg_freq) * 64'(cfg_den);
    endfunction

    function automatic logic cfg_valid();
        return cfg_freq != 0 && cfg_num != 0 && cfg_den != 0 &&
               cadence_interval() >= 64'(cfg_num);
    endfunction

    function automatic frame_result_t predict_frame(input logic [63:0] t);
        frame_result_t r;
        logic [63:0]   interval;
        logic [63:0]   elapsed;
        logic [63:0]   late;
        logic [127:0]  wide;
        logic [64:0]   due_sum;
        logic          restart;
        interval = cadence_interval();
        restart = 1'b0;
        r = '0;
        r.decision = DEC_ACCEPT;
        r.rebased = 1'b0;
        cnt_seen = cnt_seen + 1;
        if (!cfg_valid())
        begin
            cnt_bad_cfg = cnt_bad_cfg + 1;
            r.decision = DEC_BAD_CFG;
        end
        else if (t[63] || (sched_started && t < sched_last))
        begin
            cnt_bad_time = cnt_bad_time + 1;
            r.decision = DEC_BAD_TIME;
        end
        else
        begin
            sched_last = t;
            elapsed = t - sched_base;
            wide = 128'(elapsed) * 128'(cfg_num);
            due_sum = 65'(due_point) + 65'(interval);
            late = (wide[63:0] > due_point) ? wide[63:0] - due_point : 64'd0;
            if (!sched_started)
            begin
                restart = 1'b1;
                cnt_accept = cnt_accept + 1;
            end
            else if (wide[127:64] != 0)
            begin
                // Scaled elapsed time does not fit: restart the schedule here.
                restart = 1'b1;
                r.rebased = 1'b1;
                cnt_accept = cnt_accept + 1;
            end
            else if (wide[63:0] < due_point && due_point - wide[63:0] > 64'(cfg_num))
            begin
                cnt_limited = cnt_limited + 1;
                r.decision = DEC_LIMITED;
            end
            else
            begin
                cnt_accept = cnt_accept + 1;
                if (late >= interval || due_sum[64])
                begin
                    restart = 1'b1;
                    r.rebased = 1'b1;
                end
                else
                begin
                    due_point = due_sum[63:0];
                end
            end
            if (r.rebased)
                cnt_rebase = cnt_rebase + 1;
            if (restart)
            begin
                sched_base = t;
                due_point = interval;
                sched_started = 1'b1;
            end
        end
        r.seen = cnt_seen;
        r.accepted = cnt_accept;
        r.limited = cnt_limited;
        r.bad_time = cnt_bad_time;
        r.bad_cfg = cnt_bad_cfg;
        r.rebases = cnt_rebase;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_frame(input logic [63:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        frame_time <= t;
        do
            @(posedge clk);
        while (!in_ready);
        last_prediction = predict_frame(t);
        pending_results.push_back(last_prediction);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (LATENCY_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_TICK_FREQ || idx == REG_FPS_NUM || idx == REG_FPS_DEN)
        begin
            case (idx)
                REG_TICK_FREQ: cfg_freq = data[FREQ_W-1:0];
                REG_FPS_NUM:   cfg_num = data[NUM_W-1:0];
                default:       cfg_den = data[DEN_W-1:0];
            endcase
            sched_started = 1'b0;
            sched_base = '0;
            sched_last = '0;
            due_point = '0;
            cnt_seen = '0;
            cnt_accept = '0;
            cnt_limited = '0;
            cnt_bad_time = '0;
            cnt_bad_cfg = '0;
            cnt_rebase = '0;
        end
    endtask

    task automatic configure(input logic [31:0] freq, input logic [31:0] fnum,
                             input logic [31:0] fden);
        write_reg(REG_TICK_FREQ, freq);
        write_reg(REG_FPS_NUM, fnum);
        write_reg(REG_FPS_DEN, fden);
    endtask

    task automatic test_bad_config();
        send_frame(64'd0);
        send_frame(64'h7FFF_FFFF_FFFF_FFFF);
        configure(32'hFFFF_FFFF, 32'd1, 32'd0);
        send_frame(64'd100);
        configure(32'd0, 32'd0, 32'd1);
        send_frame(64'd100);
        // Interval shorter than one numerator step.
        configure(32'd1, 32'd2, 32'd1);
        send_frame(64'd100);
    endtask

    task automatic test_tolerance_edges();
        configure(32'd1000, 32'd10, 32'd1);
        send_frame(64'd500);
        send_frame(64'd598);
        send_frame(64'd599);
        send_frame(64'd599);
        send_frame(64'd598);
        send_frame(64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(64'h8000_0000_0000_0000);
        send_frame(64'd700);
        send_frame(64'd0);
    endtask

    task automatic test_late_rebase();
        configure(32'd1000, 32'd1, 32'd1);
        send_frame(64'd0);
        send_frame(64'd1000);
        send_frame(64'd3000);
        send_frame(64'd3999);
        send_frame(64'h7FFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_product_overflow();
        // Upper data bits of the rate registers must be dropped.
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(64'd0);
        send_frame(64'h0000_1000_0000_0000);
        send_frame(64'h7FFF_FFFF_FFFF_FFFF);
        send_frame(64'd0);
    endtask

    task automatic test_unused_index();
        configure(32'd90000, 32'd30, 32'd1);
        send_frame(64'd0);
        send_frame(64'd3000);
        send_frame(64'd4000);
        write_reg(REG_UNUSED, $urandom);
        send_frame(64'd6000);
        send_frame(64'd6001);
    endtask

    task automatic test_due_point_overflow();
        logic [63:0] period_ticks;
        int          k;
        // Interval is numerator times frame period, so every frame lands on its due
        // point until the due point can no longer advance.
        configure(32'hFFFF_FFFF, 32'd16, 32'h000F_FFF0);
        period_ticks = 64'(32'hFFFF_FFFF) * 64'h0000_FFFF;
        k = 0;
        do
        begin
            send_frame(64'(k) * period_ticks);
            k++;
        end
        while (!last_prediction.rebased && k < 5000);
        send_frame(64'(k) * period_ticks);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall, input int count);
        logic [63:0] period_ticks;
        logic [63:0] t;
        logic [63:0] target;
        int          kind;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        for (int seg = 0; seg < 3; seg++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                configure($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom, $urandom, $urandom);
            else if (kind == 1)
                configure($urandom_range(1, 10),
                          $urandom_range(0, 1) ? 0 : $urandom_range(1000, 1999), 32'd1);
            else
                configure($urandom_range(1000, 200000),
                          $urandom_range(1, 240) | ($urandom & 32'hFFF0_0000),
                          $urandom_range(1, 1001) | ($urandom & 32'hFFF0_0000));
            period_ticks = (cfg_num == 0) ? 64'd1000 : cadence_interval() / 64'(cfg_num);
            if (period_ticks == 0)
                period_ticks = 64'd1;
            for (int i = 0; i < count / 3; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 40)
                    t = sched_last + period_ticks / 2 + rnd_below(period_ticks + 1);
                else if (kind < 60)
                begin
                    // Aim close to the due point to work the tolerance window.
                    if (cfg_num == 0 || !sched_started)
                        t = sched_last + rnd_below(1000);
                    else
                    begin
                        target = due_point - 2 * 64'(cfg_num) + rnd_below(4 * 64'(cfg_num) + 1);
                        t = sched_base + target / 64'(cfg_num);
                        if (t < sched_last)
                            t = sched_last;
                    end
                end
                else if (kind < 75)
                    t = sched_last + rnd_below(period_ticks / 4 + 1);
                else if (kind < 85)
                    t = sched_last + period_ticks * (2 + rnd_below(4));
                else if (kind < 89)
                    t = sched_last - 1 - rnd_below(1000);
                else if (kind < 93)
                    t = rnd64() | 64'h8000_0000_0000_0000;
                else if (kind < 96)
                    t = sched_last + (64'd1 << $urandom_range(40, 60));
                else
                    t = rnd64();
                send_frame(t);
            end
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        frame_result_t got;
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {decision, rebased, seen_count, accept_count, limited_count,
                   bad_time_count, bad_config_count, rebase_count};
            if (pending_results.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected result word: decision %0d seen %0d",
                             decision, seen_count);
                fault_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    if (fault_count < 10)
                    begin
                        $display("mismatch expected: dec %0d reb %0d cnt %0d %0d %0d %0d %0d %0d",
                                 want.decision, want.rebased, want.seen, want.accepted,
                                 want.limited, want.bad_time, want.bad_cfg, want.rebases);
                        $display("         actual:   dec %0d reb %0d cnt %0d %0d %0d %0d %0d %0d",
                                 got.decision, got.rebased, got.seen, got.accepted,
                                 got.limited, got.bad_time, got.bad_cfg, got.rebases);
                    end
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_bad_config();
        test_tolerance_edges();
        send_idle_pct = 36;
        stall_pct = 36;
        test_late_rebase();
        test_product_overflow();
        test_unused_index();
        send_idle_pct = 0;
        stall_pct = 0;
        test_due_point_overflow();
        run_random_phase(0, 0, 175);
        run_random_phase(62, 0, 175);
        run_random_phase(0, 62, 175);
        run_random_phase(36, 36, 175);
        settle();
        if (fault_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
